@@ hw/rtl/qmpc_pkg.sv @@
// Shared types, constants and codes for the quad motor PWM commander.
// No dependencies; every other file in hw/rtl imports this package.

package qmpc_pkg;

   // Motor count and field widths
   localparam int MOTOR_COUNT = 4;
   localparam int MOTOR_W     = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam int MODE_W      = 3;
   localparam int CTRL_W      = 2;
   localparam int POD_W       = 2;
   localparam int GAIN_W      = 16;
   localparam int REF_W       = 16;
   localparam int PWM_W       = 15;
   localparam int COEF_W      = 32;
   localparam int OFS_W       = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_A_COEF   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_C_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_B_OFFSET = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PWM  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_PWM = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_IDLE_PWM = 3'd5;

   localparam logic [PWM_W-1:0] MAX_PWM_RESET = 15'h7FFF;

   // Drone modes, control modes, pod health
   localparam logic [MODE_W-1:0] MODE_WAIT     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TAKEOFF  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FLY      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CRITICAL = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FATAL    = 3'd5;

   localparam logic [CTRL_W-1:0] CTRL_PID_POSE = 2'd1;
   localparam logic [POD_W-1:0]  POD_STARTUP   = 2'd2;

   // Stream word layout
   localparam int REQ_TUSER_W   = MODE_W + CTRL_W;
   localparam int REQ_GAIN_LSB  = POD_W;
   localparam int REQ_REF_LSB   = POD_W + GAIN_W;
   localparam int REQ_DATA_BITS = REQ_REF_LSB + 2 * MOTOR_COUNT * REF_W;
   localparam int REQ_TDATA_W   = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = MOTOR_COUNT * PWM_W + MOTOR_COUNT;
   localparam int RSP_TDATA_W   = ((RSP_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_TUSER_W   = 1;

   // Datapath widths
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;
   localparam int WQ_W   = 25;              // |p| / 100 stays below 2^25
   localparam int D_W    = 27;              // signed difference w - c*256
   localparam int AD_W   = D_W - 1;
   localparam int FRAC_W = 24;              // Q.24 fraction dropped twice
   localparam int SUM_W  = 60;
   localparam int T_W    = SUM_W - FRAC_W;
   localparam int V_W    = T_W + 2;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for any 32 bit x
   localparam logic [MUL_W-1:0] RECIP_100   = 32'h51EB_851F;
   localparam int               RECIP_SHIFT = 37;

   // Datapath step codes
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
   localparam logic [OP_W-1:0] OP_GAIN   = 4'd1;
   localparam logic [OP_W-1:0] OP_RECIP  = 4'd2;
   localparam logic [OP_W-1:0] OP_DIFF   = 4'd3;
   localparam logic [OP_W-1:0] OP_SQUARE = 4'd4;
   localparam logic [OP_W-1:0] OP_LOW    = 4'd5;
   localparam logic [OP_W-1:0] OP_HIGH   = 4'd6;
   localparam logic [OP_W-1:0] OP_SUM    = 4'd7;
   localparam logic [OP_W-1:0] OP_CLAMP  = 4'd8;

   typedef logic [MOTOR_COUNT-1:0][PWM_W-1:0] pwm_vec_type;
   typedef logic [MOTOR_COUNT-1:0][REF_W-1:0] ref_vec_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CTRL_W-1:0] control_mode;
      logic [POD_W-1:0]  pod_status;
      logic [GAIN_W-1:0] power_gain;
      ref_vec_type       orient_ref;
      ref_vec_type       pose_ref;
   } item_type;

   typedef struct packed {
      logic               load;     // capture the input word
      logic               fill;     // write all slots for a non-mapping mode
      logic [OP_W-1:0]    op;       // one step of the speed map
      logic [MOTOR_W-1:0] motor;    // motor the step works on
      logic               finish;   // apply stop, load the output register
   } cmd_type;

   typedef struct packed {
      logic map_mode;               // mode runs the speed map
   } status_type;

endpackage

@@ hw/rtl/qmpc_ctrl.sv @@
// Sequencer of the quad motor PWM commander: walks each motor through the
// steps of the speed map and owns the stream handshakes. Depends on qmpc_pkg.

module qmpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  qmpc_pkg::status_type status,
   output qmpc_pkg::cmd_type    cmd
);
   import qmpc_pkg::*;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
   localparam logic [ST_W-1:0] ST_DECIDE = 4'd1;
   localparam logic [ST_W-1:0] ST_GAIN   = 4'd2;
   localparam logic [ST_W-1:0] ST_RECIP  = 4'd3;
   localparam logic [ST_W-1:0] ST_DIFF   = 4'd4;
   localparam logic [ST_W-1:0] ST_SQUARE = 4'd5;
   localparam logic [ST_W-1:0] ST_LOW    = 4'd6;
   localparam logic [ST_W-1:0] ST_HIGH   = 4'd7;
   localparam logic [ST_W-1:0] ST_SUM    = 4'd8;
   localparam logic [ST_W-1:0] ST_CLAMP  = 4'd9;
   localparam logic [ST_W-1:0] ST_FINISH = 4'd10;

   logic [ST_W-1:0]    state_ff, state_in;
   logic [MOTOR_W-1:0] motor_ff, motor_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      motor_in   = motor_ff;
      cmd        = '0;
      cmd.motor  = motor_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               motor_in = '0;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.map_mode) begin
               state_in = ST_GAIN;
            end else begin
               cmd.fill = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_GAIN: begin
            cmd.op   = OP_GAIN;
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            cmd.op   = OP_RECIP;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.op   = OP_SQUARE;
            state_in = ST_LOW;
         end
         ST_LOW: begin
            cmd.op   = OP_LOW;
            state_in = ST_HIGH;
         end
         ST_HIGH: begin
            cmd.op   = OP_HIGH;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.op = OP_CLAMP;
            if (motor_ff == MOTOR_W'(MOTOR_COUNT - 1)) begin
               state_in = ST_FINISH;
            end else begin
               motor_in = motor_ff + 1'b1;
               state_in = ST_GAIN;
            end
         end
         ST_FINISH: begin
            // hold until the output register is empty or being drained
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         motor_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         motor_ff     <= motor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/qmpc_datapath.sv @@
// Datapath of the quad motor PWM commander: configuration registers, held
// PWMs, one shared 32x32 multiplier and the clamp. Depends on qmpc_pkg.

module qmpc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [qmpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [qmpc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  qmpc_pkg::item_type                 req_item,
   input  qmpc_pkg::cmd_type                  cmd,
   output qmpc_pkg::status_type               status,
   output qmpc_pkg::pwm_vec_type              rsp_pwm,
   output logic                               rsp_estop,
   output logic [qmpc_pkg::MOTOR_COUNT-1:0]   rsp_mask
);
   import qmpc_pkg::*;

   logic [COEF_W-1:0]      a_coef_ff, a_coef_in;
   logic [OFS_W-1:0]       c_offset_ff, c_offset_in;
   logic [OFS_W-1:0]       b_offset_ff, b_offset_in;
   logic [PWM_W-1:0]       max_pwm_ff, max_pwm_in;
   logic [PWM_W-1:0]       zero_pwm_ff, zero_pwm_in;
   logic [PWM_W-1:0]       idle_pwm_ff, idle_pwm_in;

   item_type               item_ff, item_in;
   pwm_vec_type            last_pwm_ff, last_pwm_in;
   logic [MOTOR_COUNT-1:0] mask_ff, mask_in;
   logic                   sign_ff, sign_in;
   logic [AD_W-1:0]        ad_ff, ad_in;
   logic [MUL_W-1:0]       qh_ff, qh_in;
   logic [MUL_W-1:0]       lo_ff, lo_in;
   logic [T_W-1:0]         t_ff, t_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   pwm_vec_type            rsp_pwm_ff, rsp_pwm_in;
   logic                   rsp_estop_ff, rsp_estop_in;
   logic [MOTOR_COUNT-1:0] rsp_mask_ff, rsp_mask_in;

   logic                   use_pose;
   logic [REF_W-1:0]       ref_sel;
   logic [REF_W-1:0]       ref_mag;
   logic [MUL_W-1:0]       mul_a, mul_b;
   logic signed [D_W-1:0]  wq_s, w_s, c_sh, d_s;
   logic [SUM_W-1:0]       sum;
   logic signed [V_W-1:0]  v_s, max_s, zero_s;
   logic                   gt_max, low;
   logic [PWM_W-1:0]       clamped;
   logic                   estop;

   // Mode decode
   always_comb begin
      unique case (item_ff.mode) inside
         MODE_TAKEOFF, MODE_FLY, MODE_CRITICAL: status.map_mode = 1'b1;
         default:                               status.map_mode = 1'b0;
      endcase
   end

   assign use_pose = (item_ff.mode == MODE_FLY) && (item_ff.control_mode == CTRL_PID_POSE);
   assign ref_sel  = use_pose ? item_ff.pose_ref[cmd.motor] : item_ff.orient_ref[cmd.motor];
   assign ref_mag  = ref_sel[REF_W-1] ? REF_W'(-ref_sel) : ref_sel;

   // Truncate toward zero, then take the offset off
   assign wq_s = $signed({2'b00, prod_ff[RECIP_SHIFT +: WQ_W]});
   assign w_s  = sign_ff ? -wq_s : wq_s;
   assign c_sh = $signed({{(D_W - OFS_W - 8){c_offset_ff[OFS_W-1]}}, c_offset_ff, 8'h00});
   assign d_s  = w_s - c_sh;

   assign sum = prod_ff[SUM_W-1:0] + SUM_W'(lo_ff);

   // Clamp: upper limit first, then the lower one wins
   assign v_s    = $signed({2'b00, t_ff}) + V_W'($signed(b_offset_ff));
   assign max_s  = $signed(V_W'(max_pwm_ff));
   assign zero_s = $signed(V_W'(zero_pwm_ff));
   assign gt_max = v_s > max_s;
   assign low    = gt_max ? (max_pwm_ff < zero_pwm_ff) : (v_s < zero_s);
   assign clamped = low ? zero_pwm_ff : (gt_max ? max_pwm_ff : v_s[PWM_W-1:0]);

   assign estop = (item_ff.pod_status < POD_STARTUP) && (item_ff.mode != MODE_WAIT);

   // Configuration writes
   always_comb begin
      a_coef_in   = a_coef_ff;
      c_offset_in = c_offset_ff;
      b_offset_in = b_offset_ff;
      max_pwm_in  = max_pwm_ff;
      zero_pwm_in = zero_pwm_ff;
      idle_pwm_in = idle_pwm_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_A_COEF:   a_coef_in   = csr_wdata[COEF_W-1:0];
            REG_C_OFFSET: c_offset_in = csr_wdata[OFS_W-1:0];
            REG_B_OFFSET: b_offset_in = csr_wdata[OFS_W-1:0];
            REG_MAX_PWM:  max_pwm_in  = csr_wdata[PWM_W-1:0];
            REG_ZERO_PWM: zero_pwm_in = csr_wdata[PWM_W-1:0];
            REG_IDLE_PWM: idle_pwm_in = csr_wdata[PWM_W-1:0];
            default: ;
         endcase
      end
   end

   // Steps of the speed map, fills and the final stop
   always_comb begin
      item_in      = item_ff;
      last_pwm_in  = last_pwm_ff;
      mask_in      = mask_ff;
      sign_in      = sign_ff;
      ad_in        = ad_ff;
      qh_in        = qh_ff;
      lo_in        = lo_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      rsp_pwm_in   = rsp_pwm_ff;
      rsp_estop_in = rsp_estop_ff;
      rsp_mask_in  = rsp_mask_ff;
      mul_a        = '0;
      mul_b        = '0;

      if (cmd.load) begin
         item_in = req_item;
         mask_in = '0;
      end

      if (cmd.fill) begin
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            unique case (item_ff.mode) inside
               MODE_WAIT, MODE_FATAL: last_pwm_in[i] = zero_pwm_ff;
               MODE_IDLE:             last_pwm_in[i] = idle_pwm_ff;
               default:               last_pwm_in[i] = last_pwm_ff[i];
            endcase
         end
      end

      unique case (cmd.op)
         OP_GAIN: begin
            sign_in = ref_sel[REF_W-1];
            mul_a   = MUL_W'(item_ff.power_gain);
            mul_b   = MUL_W'(ref_mag);
            prod_in = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
         end
         OP_RECIP: begin
            mul_a   = prod_ff[MUL_W-1:0];
            mul_b   = RECIP_100;
            prod_in = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
         end
         OP_DIFF: begin
            ad_in = d_s[D_W-1] ? AD_W'(-d_s) : AD_W'(d_s);
         end
         OP_SQUARE: begin
            mul_a   = MUL_W'(ad_ff);
            mul_b   = MUL_W'(ad_ff);
            prod_in = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
         end
         OP_LOW: begin
            qh_in   = prod_ff[FRAC_W +: MUL_W];
            mul_a   = a_coef_ff;
            mul_b   = MUL_W'(prod_ff[FRAC_W-1:0]);
            prod_in = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
         end
         OP_HIGH: begin
            lo_in   = prod_ff[FRAC_W +: MUL_W];
            mul_a   = a_coef_ff;
            mul_b   = qh_ff;
            prod_in = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
         end
         OP_SUM: begin
            t_in = sum[SUM_W-1:FRAC_W];
         end
         OP_CLAMP: begin
            last_pwm_in[cmd.motor] = clamped;
            mask_in[cmd.motor]     = low;
         end
         default: ;
      endcase

      if (cmd.finish) begin
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            if (estop) begin
               last_pwm_in[i] = zero_pwm_ff;
               rsp_pwm_in[i]  = zero_pwm_ff;
            end else begin
               rsp_pwm_in[i]  = last_pwm_ff[i];
            end
         end
         rsp_estop_in = estop;
         rsp_mask_in  = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_coef_ff   <= '0;
         c_offset_ff <= '0;
         b_offset_ff <= '0;
         max_pwm_ff  <= MAX_PWM_RESET;
         zero_pwm_ff <= '0;
         idle_pwm_ff <= '0;
         last_pwm_ff <= '0;
      end else begin
         a_coef_ff   <= a_coef_in;
         c_offset_ff <= c_offset_in;
         b_offset_ff <= b_offset_in;
         max_pwm_ff  <= max_pwm_in;
         zero_pwm_ff <= zero_pwm_in;
         idle_pwm_ff <= idle_pwm_in;
         last_pwm_ff <= last_pwm_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      mask_ff      <= mask_in;
      sign_ff      <= sign_in;
      ad_ff        <= ad_in;
      qh_ff        <= qh_in;
      lo_ff        <= lo_in;
      t_ff         <= t_in;
      prod_ff      <= prod_in;
      rsp_pwm_ff   <= rsp_pwm_in;
      rsp_estop_ff <= rsp_estop_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   assign rsp_pwm   = rsp_pwm_ff;
   assign rsp_estop = rsp_estop_ff;
   assign rsp_mask  = rsp_mask_ff;

endmodule

@@ hw/rtl/quad_motor_pwm_commander_unit.sv @@
// Top level of the quad motor PWM commander: stream ports, word packing,
// sequencer and datapath. Depends on qmpc_pkg, qmpc_ctrl, qmpc_datapath.
//
//  channel  direction  handshake              payload
//  req_     in         req_tvalid/req_tready  req_tdata, req_tuser
//  rsp_     out        rsp_tvalid/rsp_tready  rsp_tdata, rsp_tuser
//  csr_     in         csr_we                 csr_index, csr_wdata
//
// A word in takeoff, critical or fly mode runs the speed map for
// each motor in turn through one shared 32x32 multiplier, in the steps
// gain, recip, diff, square, low, high, sum and clamp; in wait, idle, fatal
// and unknown modes the held PWMs are filled or kept without the map. A new
// word is accepted in the cycle after the result is loaded, and none while
// a word is being worked on.
// Synchronous active-high reset: configuration registers take their
// listed reset values, held PWMs go to zero, both channels idle.
// A result that is not taken stays in the output register while the next
// word is accepted and worked on; that word waits only at its own finish.

module quad_motor_pwm_commander_unit (
   input  logic                               clock,
   input  logic                               reset,
   // csr_ write port
   input  logic                               csr_we,
   input  logic [qmpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [qmpc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // req_ stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pod_status, power_gain, orient_ref_0..3, pose_ref_0..3, zero fill
   input  logic [qmpc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // mode, control_mode
   input  logic [qmpc_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // rsp_ stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pwm_0..3, low_clamp_mask
   output logic [qmpc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // emergency_stop
   output logic [qmpc_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import qmpc_pkg::*;

   item_type               req_item;
   cmd_type                cmd;
   status_type             status;
   pwm_vec_type            rsp_pwm;
   logic                   rsp_estop;
   logic [MOTOR_COUNT-1:0] rsp_mask;

   // Unpack the input word
   always_comb begin
      req_item.mode         = req_tuser[MODE_W-1:0];
      req_item.control_mode = req_tuser[MODE_W +: CTRL_W];
      req_item.pod_status   = req_tdata[POD_W-1:0];
      req_item.power_gain   = req_tdata[REQ_GAIN_LSB +: GAIN_W];
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         req_item.orient_ref[i] = req_tdata[REQ_REF_LSB + i * REF_W +: REF_W];
         req_item.pose_ref[i]   = req_tdata[REQ_REF_LSB + (MOTOR_COUNT + i) * REF_W +: REF_W];
      end
   end

   qmpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   qmpc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_pwm   (rsp_pwm),
      .rsp_estop (rsp_estop),
      .rsp_mask  (rsp_mask)
   );

   // Pack the result word: PWMs from motor 0 up, then the low clamp mask
   assign rsp_tdata = RSP_TDATA_W'({rsp_mask, rsp_pwm});
   assign rsp_tuser = RSP_TUSER_W'(rsp_estop);

   // Result loads only into an empty or draining output register
   a_finish_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a word still waiting");

   // A finished word shows up on the result side in the next cycle
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_tvalid)
      else $error("finished word not presented");

   // Busy after accepting a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word accepted while busy");

   // Load, fill, map step and finish never coincide
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.fill, cmd.finish, cmd.op != OP_NONE}))
      else $error("overlapping datapath commands");

endmodule
